FILE: rtl/run_length_bitmap_line_decoder_defines.svh
// Assertion macros used by the decoder's top-level RTL file.
`ifndef RUN_LENGTH_BITMAP_LINE_DECODER_DEFINES_SVH
`define RUN_LENGTH_BITMAP_LINE_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLBD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RLBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rlbd_pkg.sv
`default_nettype none

package rlbd_pkg;

   localparam int WORD_BITS      = 32;
   localparam int OFFSET_W       = 5;
   localparam int COL_W          = 11;
   localparam int RUN_W          = 8;
   localparam int CSR_W          = 7;
   localparam int SPAN_W         = 6;
   localparam int MAX_LINE_WORDS = 64;

   localparam logic [CSR_W-1:0] RESET_LINE_WORDS = 7'd10;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic [SPAN_W-1:0]    span;
      logic [WORD_BITS-1:0] mask;
      logic [COL_W:0]       next_col;
      logic [RUN_W-1:0]     rem_next;
      logic                 word_done;
   } step_type;

endpackage

`default_nettype wire

FILE: rtl/rlbd_step.sv
`default_nettype none

// Computes one span: the pixels of the run that fit in the current word.
module rlbd_step (
   input  wire logic [rlbd_pkg::COL_W-1:0] col,
   input  wire logic [rlbd_pkg::RUN_W-1:0] rem,
   output rlbd_pkg::step_type              step
);

   logic [rlbd_pkg::OFFSET_W-1:0]  lo;
   logic [rlbd_pkg::SPAN_W-1:0]    room;
   logic [rlbd_pkg::SPAN_W-1:0]    span;
   logic [rlbd_pkg::SPAN_W-1:0]    hi;
   logic [rlbd_pkg::WORD_BITS-1:0] upper;
   logic [rlbd_pkg::WORD_BITS-1:0] lower;

   always_comb begin
      lo    = col[rlbd_pkg::OFFSET_W-1:0];
      room  = rlbd_pkg::SPAN_W'(rlbd_pkg::WORD_BITS) - {1'b0, lo};
      span  = (rem < {2'b00, room}) ? rem[rlbd_pkg::SPAN_W-1:0] : room;
      hi    = {1'b0, lo} + span;
      upper = hi[rlbd_pkg::SPAN_W-1] ? '1 :
              ((rlbd_pkg::WORD_BITS'(1) << hi[rlbd_pkg::OFFSET_W-1:0]) -
               rlbd_pkg::WORD_BITS'(1));
      lower = '1 << lo;

      step.span      = span;
      step.mask      = upper & lower;
      step.next_col  = {1'b0, col} + (rlbd_pkg::COL_W + 1)'(span);
      step.rem_next  = rem - {2'b00, span};
      step.word_done = hi[rlbd_pkg::SPAN_W-1];
   end

endmodule

`default_nettype wire

FILE: rtl/run_length_bitmap_line_decoder.sv
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata: run_length
// rsp       out        rsp_tvalid/rsp_tready  tdata: pixel_word, tuser: line_end, tlast: last
// csr       in         csr_wr_en              csr_wr_data: line_words
//
// A byte is taken while the decoder is idle, then fills at most one word per cycle
// while no waiting result word stalls the span unit, which fills one word at a time.
// The decoder takes no new byte while one is in work.
// Reset is synchronous and active high and returns the line to column 0, black.
// A waiting result word stalls the span unit until the word is taken.
`default_nettype none

`include "run_length_bitmap_line_decoder_defines.svh"

module run_length_bitmap_line_decoder #(
   parameter int MAX_LINE_WORDS = rlbd_pkg::MAX_LINE_WORDS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] run_length
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] pixel_word
   output logic             rsp_tuser,   // [0] line_end
   output logic             rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data  // [6:0] line_words
);

   localparam int MW_W  = $clog2(MAX_LINE_WORDS + 1);
   localparam int EW    = (MW_W > rlbd_pkg::CSR_W) ? MW_W : rlbd_pkg::CSR_W;
   localparam int CMP_W = EW + rlbd_pkg::OFFSET_W;

   rlbd_pkg::state_type state_ff, state_in;

   logic [rlbd_pkg::CSR_W-1:0]     line_words_ff;
   logic [rlbd_pkg::COL_W-1:0]     col_ff, col_in;
   logic [rlbd_pkg::RUN_W-1:0]     rem_ff, rem_in;
   logic                           white_ff, white_in;
   logic [rlbd_pkg::WORD_BITS-1:0] acc_ff, acc_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rlbd_pkg::WORD_BITS-1:0] rsp_word_ff, rsp_word_in;
   logic                           rsp_eol_ff, rsp_eol_in;
   logic                           rsp_last_ff, rsp_last_in;

   rlbd_pkg::step_type             step;
   logic [EW-1:0]                  eff_words;
   logic [CMP_W-1:0]               limit;
   logic [rlbd_pkg::WORD_BITS-1:0] acc_new;
   logic                           can_go;
   logic                           eol;
   logic                           emit;
   logic                           accept;

   rlbd_step u_step (
      .col  (col_ff),
      .rem  (rem_ff),
      .step (step)
   );

   always_comb begin
      if (line_words_ff == '0) begin
         eff_words = EW'(1);
      end else if (EW'(line_words_ff) > EW'(MAX_LINE_WORDS)) begin
         eff_words = EW'(MAX_LINE_WORDS);
      end else begin
         eff_words = EW'(line_words_ff);
      end
      limit = CMP_W'(eff_words) << rlbd_pkg::OFFSET_W;
   end

   assign accept  = req_tvalid && req_tready;
   assign can_go  = !rsp_valid_ff || rsp_tready;
   assign acc_new = acc_ff | (white_ff ? step.mask : '0);
   assign eol     = CMP_W'(step.next_col) >= limit;
   assign emit    = (state_ff == rlbd_pkg::ST_RUN) && can_go && (rem_ff != '0) &&
                    step.word_done;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rlbd_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = rlbd_pkg::ST_RUN;
            end
         end
         rlbd_pkg::ST_RUN: begin
            if (can_go && ((rem_ff == '0) || (emit && eol) || (step.rem_next == '0))) begin
               state_in = rlbd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rlbd_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      col_in       = col_ff;
      rem_in       = rem_ff;
      white_in     = white_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_word_in  = rsp_word_ff;
      rsp_eol_in   = rsp_eol_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;
      case (state_ff)
         rlbd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               rem_in = req_tdata;
            end
         end
         rlbd_pkg::ST_RUN: begin
            if (can_go) begin
               if (rem_ff == '0) begin
                  white_in = !white_ff;
               end else if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = acc_new;
                  rsp_eol_in   = eol;
                  rsp_last_in  = eol ||
                                 (step.rem_next < rlbd_pkg::RUN_W'(rlbd_pkg::WORD_BITS));
                  acc_in       = '0;
                  if (eol) begin
                     col_in   = '0;
                     white_in = 1'b0;
                     rem_in   = '0;
                  end else begin
                     col_in = step.next_col[rlbd_pkg::COL_W-1:0];
                     rem_in = step.rem_next;
                     if (step.rem_next == '0) begin
                        white_in = !white_ff;
                     end
                  end
               end else begin
                  acc_in   = acc_new;
                  col_in   = step.next_col[rlbd_pkg::COL_W-1:0];
                  rem_in   = step.rem_next;
                  white_in = !white_ff;
               end
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rlbd_pkg::ST_IDLE;
         line_words_ff <= rlbd_pkg::RESET_LINE_WORDS;
         col_ff        <= '0;
         rem_ff        <= '0;
         white_ff      <= 1'b0;
         acc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         rem_ff       <= rem_in;
         white_ff     <= white_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            line_words_ff <= csr_wr_data[rlbd_pkg::CSR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      rsp_eol_ff  <= rsp_eol_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_eol_ff;
   assign rsp_tlast  = rsp_last_ff;

   `RLBD_ASSERT_SAME(a_eol_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast, "line end word must close its byte")
   `RLBD_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready, "decoder must be busy after taking a byte")
   `RLBD_ASSERT_NEXT(a_emit_aligned, clock, reset, emit, col_ff[rlbd_pkg::OFFSET_W-1:0] == '0, "column must be word aligned after a word")

endmodule

`default_nettype wire

FILE: bench/run_length_bitmap_line_decoder_checker.sv
`default_nettype none

module run_length_bitmap_line_decoder_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,
   output int               failures,
   output int               outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [rlbd_pkg::WORD_BITS-1:0] pixels;
      logic                           line_end;
      logic                           last;
   } line_word_type;

   line_word_type                  expected_words[$];
   logic [rlbd_pkg::CSR_W-1:0]     width_words;
   int unsigned                    column;
   logic                           white;
   logic [rlbd_pkg::WORD_BITS-1:0] accum;

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
      failures++;
   endtask

   // Paints one run into the current line and queues every word it completes.
   task automatic decode_run(input logic [rlbd_pkg::RUN_W-1:0] run);
      int unsigned   limit;
      int unsigned   next;
      int unsigned   words;
      int            first;
      bit            ended;
      line_word_type item;
      words = width_words;
      if (words == 0) words = 1;
      if (words > rlbd_pkg::MAX_LINE_WORDS) words = rlbd_pkg::MAX_LINE_WORDS;
      limit = words * rlbd_pkg::WORD_BITS;
      first = expected_words.size();
      ended = 0;
      for (int i = 0; i < run && !ended; i++) begin
         if (white) accum[column % rlbd_pkg::WORD_BITS] = 1'b1;
         next = column + 1;
         if (next % rlbd_pkg::WORD_BITS == 0) begin
            item.pixels   = accum;
            item.line_end = (next >= limit);
            item.last     = 1'b0;
            expected_words.push_back(item);
            accum = '0;
            if (next >= limit) begin
               column = 0;
               white  = 1'b0;
               ended  = 1;
            end
         end
         if (!ended) column = next % (1 << rlbd_pkg::COL_W);
      end
      if (!ended) white = !white;
      if (expected_words.size() > first) begin
         item = expected_words.pop_back();
         item.last = 1'b1;
         expected_words.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      line_word_type want;
      if (reset) begin
         width_words = rlbd_pkg::RESET_LINE_WORDS;
         column      = 0;
         white       = 1'b0;
         accum       = '0;
         expected_words.delete();
      end else begin
         if (csr_wr_en) width_words = csr_wr_data[rlbd_pkg::CSR_W-1:0];
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("word with nothing expected", rsp_tdata, '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata !== want.pixels)
                  report_mismatch("pixel_word", rsp_tdata, want.pixels);
               if (rsp_tuser !== want.line_end)
                  report_mismatch("line_end", 32'(rsp_tuser), 32'(want.line_end));
               if (rsp_tlast !== want.last)
                  report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
            end
         end
         if (req_tvalid && req_tready) decode_run(req_tdata);
      end
      outstanding <= expected_words.size();
   end

endmodule

`default_nettype wire

FILE: bench/run_length_bitmap_line_decoder_tb.sv
`default_nettype none

module run_length_bitmap_line_decoder_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 1000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;
   int          failures;
   int          outstanding;
   int          burst_left  = 1;
   int          ready_mode  = 0;
   int          mode_cycles = 0;

   run_length_bitmap_line_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   run_length_bitmap_line_decoder_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver switches between always ready, random stalls and a fixed stall beat.
   always @(posedge clock) begin
      if (mode_cycles == 0) begin
         ready_mode  <= $urandom_range(0, 2);
         mode_cycles <= $urandom_range(16, 80);
      end else begin
         mode_cycles <= mode_cycles - 1;
      end
      case (ready_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_tready <= ((mode_cycles % 7) < 4);
         end
      endcase
   end

   task automatic send_run(input logic [7:0] run);
      req_tvalid <= 1'b1;
      req_tdata  <= run;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom_range(0, 255);
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // The decoder may still be busy on a byte that yields no word, so wait on after
   // the last expected word before touching the register.
   task automatic set_line_words(input logic [7:0] value);
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= $urandom_range(0, 255);
   endtask

   function automatic logic [7:0] pick_run();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1, 2:    return 8'(255 - $urandom_range(0, 3));
         3:       return 8'($urandom_range(1, 8));
         4:       return 8'($urandom_range(31, 33));
         5:       return 8'(32 * $urandom_range(2, 4));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("run_length_bitmap_line_decoder: mismatch");
      $finish;
   end

   initial begin
      logic [7:0] width_value;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset width of ten words: zero runs, full runs, word edges, overshoot.
      send_run(8'd0);
      send_run(8'd255);
      send_run(8'd1);
      send_run(8'd31);
      send_run(8'd32);
      send_run(8'd33);
      send_run(8'd255);
      send_run(8'd0);
      send_run(8'd0);
      send_run(8'd128);

      // A width of zero behaves as one word.
      set_line_words(8'd0);
      send_run(8'd255);
      send_run(8'd31);
      send_run(8'd1);
      send_run(8'd40);
      send_run(8'd0);
      send_run(8'd32);

      // Above the maximum the width saturates; bit 7 of the port is ignored.
      set_line_words(8'hFF);
      send_run(8'd100);
      send_run(8'd100);

      // Shrink the width in the middle of a line.
      set_line_words(8'd1);
      send_run(8'd50);
      send_run(8'd10);
      send_run(8'd255);

      set_line_words(8'd64);
      send_run(8'd255);
      send_run(8'd170);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0:       width_value = 8'd1;
            1:       width_value = 8'd127;
            2:       width_value = 8'd64;
            3:       width_value = 8'd65;
            4:       width_value = 8'd2;
            default: width_value = 8'($urandom_range(0, 127));
         endcase
         width_value[7] = $urandom_range(0, 1);
         set_line_words(width_value);
         repeat (25) send_run(pick_run());
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("run_length_bitmap_line_decoder: match");
      end else begin
         $display("run_length_bitmap_line_decoder: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: run_length_bitmap_line_decoder.f
+incdir+rtl
rtl/rlbd_pkg.sv
rtl/rlbd_step.sv
rtl/run_length_bitmap_line_decoder.sv
bench/run_length_bitmap_line_decoder_checker.sv
bench/run_length_bitmap_line_decoder_tb.sv
